>>> sv/tabiq_pkg.sv
package tabiq_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 28;
  localparam int COEF_W         = 32;
  localparam int NUM_AXES       = 3;

  // Five products of COEF_W x SAMPLE_BITS need three guard bits.
  localparam int ACC_W   = COEF_W + SAMPLE_BITS + 3;
  // The sum is multiplied by gain in two halves on the shared multiplier.
  localparam int HALF_W  = (ACC_W + 1) / 2;
  localparam int MUL_B_W = HALF_W + 1;
  localparam int PROD_W  = COEF_W + MUL_B_W;
  // Full gain * sum product and the scaling back to integer samples.
  localparam int FIN_W   = ACC_W + COEF_W;
  localparam int SHIFT   = 2 * COEF_FRAC_BITS;
  localparam int RES_W   = FIN_W - SHIFT;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  localparam coef_t   COEF_ONE   = coef_t'(64'sd1 <<< COEF_FRAC_BITS);
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_GAIN = 3'd0,
    REG_B0   = 3'd1,
    REG_B1   = 3'd2,
    REG_B2   = 3'd3,
    REG_A1   = 3'd4,
    REG_A2   = 3'd5
  } cfg_reg_t;

endpackage

>>> sv/tabiq_mul.sv
// Shared signed multiplier with a registered product.
module tabiq_mul import tabiq_pkg::*; (
  input  logic                      clk,
  input  logic signed [COEF_W-1:0]  mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

endmodule

>>> sv/three_axis_biquad_iir_top.sv
// Three-axis biquad IIR filter (direct form I) for accelerometer samples. Each transfer on the
// input channel carries one signed sample per axis and a start_of_block mark; each produces
// exactly one result transfer with the three filtered values and a clipped flag. Every axis is
// filtered by the same coefficients: out = gain*(b0*x0 + b1*x1 + b2*x2 - a1*y1 - a2*y2), with
// Q4.28 coefficients, an exact sum, truncation toward minus infinity and saturation to 16 bits.
// The first two samples after reset or after a start_of_block mark give zero outputs; their
// inputs still enter the input history and zeros enter the output history. After the input
// transfer of a filtered sample, every axis runs ten steps on one shared 32 x 27 bit
// multiplier (five multiply-accumulate steps and their drain, two half products of the sum by
// gain, one wide add, one saturation step), then the done state hands the result to the output
// register. Warm-up samples pass the warm-up and done states only. in_stall is high while an item is being
// processed; the next item is taken as soon as the previous one sits in the output register,
// even if that result has not been transferred yet. Coefficients are written through the
// configuration channel, which is always ready; they should be changed only while idle.
module three_axis_biquad_iir_top import tabiq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [COEF_W-1:0]       cfg_data,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SAMPLE_BITS-1:0] x_sample,
  input  logic signed [SAMPLE_BITS-1:0] y_sample,
  input  logic signed [SAMPLE_BITS-1:0] z_sample,
  input  logic                    start_of_block,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SAMPLE_BITS-1:0] x_filtered,
  output logic signed [SAMPLE_BITS-1:0] y_filtered,
  output logic signed [SAMPLE_BITS-1:0] z_filtered,
  output logic                    clipped
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_MAC,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_FIN,
    ST_SAT,
    ST_DONE
  } state_t;

  // Multiply-accumulate step codes; the last one only drains the final product.
  localparam logic [2:0] TAP_B0   = 3'd0;
  localparam logic [2:0] TAP_B1   = 3'd1;
  localparam logic [2:0] TAP_B2   = 3'd2;
  localparam logic [2:0] TAP_A1   = 3'd3;
  localparam logic [2:0] TAP_A2   = 3'd4;
  localparam logic [2:0] TAP_LAST = 3'd5;

  localparam logic [1:0] AXIS_LAST = 2'(NUM_AXES - 1);
  localparam logic [1:0] POS_FULL  = 2'd2;

  state_t state;
  logic [2:0] tap;
  logic [1:0] axis;
  logic [1:0] block_pos;
  logic       neg_term;

  coef_t gain, b0_coef, b1_coef, b2_coef, a1_coef, a2_coef;

  sample_t samp  [NUM_AXES];
  sample_t x_h1  [NUM_AXES];
  sample_t x_h2  [NUM_AXES];
  sample_t y_h1  [NUM_AXES];
  sample_t y_h2  [NUM_AXES];
  sample_t res   [NUM_AXES];
  logic    clip_acc;

  logic signed [ACC_W-1:0] acc;
  logic signed [FIN_W-1:0] fin;

  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  coef_t   coef_sel;
  sample_t samp_sel;
  logic signed [FIN_W-1:0] prod_ext;
  logic signed [RES_W-1:0] fin_top;
  logic    fits;
  sample_t sat_val;
  logic [1:0] pos_eff;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  // Operand selection for the current multiply-accumulate step.
  always_comb begin
    case (tap)
      TAP_B0:  coef_sel = b0_coef;
      TAP_B1:  coef_sel = b1_coef;
      TAP_B2:  coef_sel = b2_coef;
      TAP_A1:  coef_sel = a1_coef;
      default: coef_sel = a2_coef;
    endcase
    case (tap)
      TAP_B0:  samp_sel = samp[axis];
      TAP_B1:  samp_sel = x_h1[axis];
      TAP_B2:  samp_sel = x_h2[axis];
      TAP_A1:  samp_sel = y_h1[axis];
      default: samp_sel = y_h2[axis];
    endcase
  end

  // The sum is split into an unsigned low half and a signed high half for the gain multiply.
  always_comb begin
    unique case (state)
      ST_MAC: begin
        mul_a = coef_sel;
        mul_b = {{(MUL_B_W-SAMPLE_BITS){samp_sel[SAMPLE_BITS-1]}}, samp_sel};
      end
      ST_GAIN_LO: begin
        mul_a = gain;
        mul_b = {1'b0, acc[HALF_W-1:0]};
      end
      ST_GAIN_HI: begin
        mul_a = gain;
        mul_b = {{(MUL_B_W-(ACC_W-HALF_W)){acc[ACC_W-1]}}, acc[ACC_W-1:HALF_W]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tabiq_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign prod_ext = {{(FIN_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Scale back by the two fraction widths (floor), then saturate to the sample range.
  assign fin_top = fin[FIN_W-1:SHIFT];
  assign fits    = (&fin_top[RES_W-1:SAMPLE_BITS-1]) | ~(|fin_top[RES_W-1:SAMPLE_BITS-1]);
  assign sat_val = fits ? fin_top[SAMPLE_BITS-1:0]
                        : (fin_top[RES_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

  assign pos_eff = start_of_block ? 2'd0 : block_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= TAP_B0;
      axis      <= '0;
      block_pos <= '0;
      out_valid <= 1'b0;
      gain      <= COEF_ONE;
      b0_coef   <= COEF_ONE;
      b1_coef   <= '0;
      b2_coef   <= '0;
      a1_coef   <= '0;
      a2_coef   <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        x_h1[i] <= '0;
        x_h2[i] <= '0;
        y_h1[i] <= '0;
        y_h2[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GAIN: gain    <= cfg_data;
          REG_B0:   b0_coef <= cfg_data;
          REG_B1:   b1_coef <= cfg_data;
          REG_B2:   b2_coef <= cfg_data;
          REG_A1:   a1_coef <= cfg_data;
          REG_A2:   a2_coef <= cfg_data;
          default: ;
        endcase
      end

      // In the done state the output register is handled below.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            samp[0]   <= x_sample;
            samp[1]   <= y_sample;
            samp[2]   <= z_sample;
            axis      <= '0;
            tap       <= TAP_B0;
            acc       <= '0;
            clip_acc  <= 1'b0;
            block_pos <= (pos_eff == POS_FULL) ? POS_FULL : pos_eff + 2'd1;
            state     <= (pos_eff == POS_FULL) ? ST_MAC : ST_WARM;
          end
        end

        ST_WARM: begin
          // Warm-up: inputs enter the history, zeros go out and into the output history.
          for (int i = 0; i < NUM_AXES; i++) begin
            x_h2[i] <= x_h1[i];
            x_h1[i] <= samp[i];
            y_h2[i] <= y_h1[i];
            y_h1[i] <= '0;
            res[i]  <= '0;
          end
          state <= ST_DONE;
        end

        ST_MAC: begin
          // The product of the previous step is added here; feedback terms are subtracted.
          if (tap != TAP_B0) begin
            if (neg_term) begin
              acc <= acc - $signed(prod[ACC_W-1:0]);
            end else begin
              acc <= acc + $signed(prod[ACC_W-1:0]);
            end
          end
          neg_term <= (tap == TAP_A1) || (tap == TAP_A2);
          if (tap == TAP_LAST) begin
            state <= ST_GAIN_LO;
          end else begin
            tap <= tap + 3'd1;
          end
        end

        ST_GAIN_LO: begin
          state <= ST_GAIN_HI;
        end

        ST_GAIN_HI: begin
          fin   <= prod_ext;
          state <= ST_FIN;
        end

        ST_FIN: begin
          fin   <= fin + (prod_ext <<< HALF_W);
          state <= ST_SAT;
        end

        ST_SAT: begin
          res[axis]  <= sat_val;
          clip_acc   <= clip_acc | ~fits;
          x_h2[axis] <= x_h1[axis];
          x_h1[axis] <= samp[axis];
          y_h2[axis] <= y_h1[axis];
          y_h1[axis] <= sat_val;
          if (axis == AXIS_LAST) begin
            state <= ST_DONE;
          end else begin
            axis  <= axis + 2'd1;
            tap   <= TAP_B0;
            acc   <= '0;
            state <= ST_MAC;
          end
        end

        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            x_filtered <= res[0];
            y_filtered <= res[1];
            z_filtered <= res[2];
            clipped    <= clip_acc;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // The block position saturates at two and never reaches three.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    block_pos != 2'd3)
    else $error("block position out of range");

  // An accepted item always starts either warm-up or filtering.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_WARM || state == ST_MAC))
    else $error("accepted item did not start processing");

  // A clipped result has at least one axis at a saturation limit.
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (x_filtered == SAMPLE_MAX || x_filtered == SAMPLE_MIN ||
       y_filtered == SAMPLE_MAX || y_filtered == SAMPLE_MIN ||
       z_filtered == SAMPLE_MAX || z_filtered == SAMPLE_MIN))
    else $error("clipped set without a saturated axis");

  // The sequencer counters stay inside their ranges while filtering.
  a_seq_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> (tap <= TAP_LAST && axis <= AXIS_LAST))
    else $error("sequencer counter out of range");

endmodule

>>> tb/three_axis_biquad_iir_top_tb.sv
module three_axis_biquad_iir_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tabiq_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  // Margin left after the last transfer before the pipeline is taken to be quiet.
  localparam int SETTLE_CYCLES  = 40;
  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT    = 3000;
  localparam int WARMUP_SAMPLES = 2;
  localparam int NUM_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 40;

  // Register indexes past the last coefficient; writes there must change nothing.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam coef_t COEF_MAX = 32'sh7FFF_FFFF;
  localparam coef_t COEF_MIN = 32'sh8000_0000;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
    logic    clip;
  } filt_res_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // One line of the directed table: either a register write or a sample, where a sample may
  // carry a hand-written expected result instead of the one the predictor works out.
  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] idx;
    coef_t      data;
    sample_t    x;
    sample_t    y;
    sample_t    z;
    logic       sob;
    logic       typed;
    filt_res_t  want;
  } dir_row_t;

  typedef enum logic [2:0] {
    CFG_RESET, CFG_FILTER, CFG_RANDOM, CFG_ALL_MAX, CFG_ALL_MIN, CFG_SMALL
  } cfg_style_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  sample_t    x_sample;
  sample_t    y_sample;
  sample_t    z_sample;
  logic       start_of_block;
  logic       out_valid;
  logic       out_stall;
  sample_t    x_filtered;
  sample_t    y_filtered;
  sample_t    z_filtered;
  logic       clipped;

  three_axis_biquad_iir_top u_dut (.*);

  // Our own copy of the filter: coefficients, two samples of input and output history per
  // axis, and how far the current block is into its warm-up.
  coef_t       coef_now [6];
  sample_t     in_hist  [NUM_AXES][2];
  sample_t     out_hist [NUM_AXES][2];
  int unsigned warm_count;

  filt_res_t   filtered_q [$];
  filt_res_t   pending_result;
  dir_row_t    dir_rows [$];
  int          fail_count;
  int          send_gap_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Exact direct form I for one axis. The five products and their sum fit easily in 128 bits,
  // as does the product with gain; the arithmetic shift truncates toward minus infinity.
  function automatic sample_t biquad_axis(sample_t x0, sample_t x1, sample_t x2,
                                          sample_t y1, sample_t y2, output logic sat);
    logic signed [127:0] tap_sum;
    logic signed [127:0] scaled;
    tap_sum = coef_now[REG_B0] * x0 + coef_now[REG_B1] * x1 + coef_now[REG_B2] * x2
            - coef_now[REG_A1] * y1 - coef_now[REG_A2] * y2;
    scaled  = (tap_sum * coef_now[REG_GAIN]) >>> SHIFT;
    sat = 1'b1;
    if (scaled > SAMPLE_MAX) return SAMPLE_MAX;
    if (scaled < SAMPLE_MIN) return SAMPLE_MIN;
    sat = 1'b0;
    return sample_t'(scaled);
  endfunction

  // Advances the filter state by one sample and returns the result it should produce.
  function automatic filt_res_t filter_step(sample_t xs, sample_t ys, sample_t zs, logic sob);
    filt_res_t r;
    sample_t   fresh [NUM_AXES];
    sample_t   res   [NUM_AXES];
    logic      sat;
    fresh[0] = xs;
    fresh[1] = ys;
    fresh[2] = zs;
    if (sob) warm_count = 0;
    r.clip = 1'b0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      if (warm_count < WARMUP_SAMPLES) begin
        res[ax] = '0;
      end else begin
        res[ax] = biquad_axis(fresh[ax], in_hist[ax][0], in_hist[ax][1],
                              out_hist[ax][0], out_hist[ax][1], sat);
        r.clip |= sat;
      end
      // Warm-up samples still enter the input history; their zero outputs enter the other.
      in_hist[ax][1]  = in_hist[ax][0];
      in_hist[ax][0]  = fresh[ax];
      out_hist[ax][1] = out_hist[ax][0];
      out_hist[ax][0] = res[ax];
    end
    if (warm_count < WARMUP_SAMPLES) warm_count++;
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    return r;
  endfunction

  function automatic coef_t pick_coef(cfg_style_t style, int r);
    case (style)
      CFG_RESET:   return (r == REG_GAIN || r == REG_B0) ? COEF_ONE : '0;
      // Coefficients of a plausible filter: gain between 0.5 and 1.5, weights within +-1.0.
      CFG_FILTER:  return (r == REG_GAIN) ? coef_t'(COEF_ONE / 2 + $urandom_range(COEF_ONE))
                                          : coef_t'(int'($urandom_range(2 * COEF_ONE))
                                                    - COEF_ONE);
      CFG_SMALL:   return coef_t'(int'($urandom_range(1 << 21)) - (1 << 20));
      CFG_ALL_MAX: return COEF_MAX;
      CFG_ALL_MIN: return COEF_MIN;
      default:     return coef_t'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(19))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return sample_t'(int'($urandom_range(200)) - 100);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic add_checked(sample_t xs, sample_t ys, sample_t zs, logic sob,
                             sample_t ex, sample_t ey, sample_t ez, logic eclip);
    dir_row_t row;
    row = '0;
    row.kind  = ROW_SAMPLE;
    row.x     = xs;
    row.y     = ys;
    row.z     = zs;
    row.sob   = sob;
    row.typed = 1'b1;
    row.want  = '{x: ex, y: ey, z: ez, clip: eclip};
    dir_rows.push_back(row);
  endtask

  task automatic add_item(sample_t xs, sample_t ys, sample_t zs, logic sob);
    dir_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.x    = xs;
    row.y    = ys;
    row.z    = zs;
    row.sob  = sob;
    dir_rows.push_back(row);
  endtask

  task automatic add_write(logic [2:0] idx, coef_t data);
    dir_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    dir_rows.push_back(row);
  endtask

  // Register write transfer; our coefficient copy follows at the handshake.
  task automatic write_reg(logic [2:0] idx, coef_t data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_A2) coef_now[idx] = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Presents one sample after a random gap and holds it until the input transfer happens.
  // The predictor runs at presentation, which is safe because a presented sample is never
  // taken back; the expected result is queued by the checker at the handshake itself.
  task automatic send_sample(sample_t xs, sample_t ys, sample_t zs, logic sob,
                             logic typed, filt_res_t typed_res);
    filt_res_t model;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    model = filter_step(xs, ys, zs, sob);
    pending_result = typed ? typed_res : model;
    x_sample       = xs;
    y_sample       = ys;
    z_sample       = zs;
    start_of_block = sob;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending and waits for every outstanding result. With settle set it also lets the
  // pipeline go fully quiet, which is required before a coefficient write.
  task automatic wait_drained(logic settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Receiver side: random stall, changed only at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Scoreboard. A result transfer is matched first against the oldest expectation, then a
  // sample transfer at the same edge queues its own; a result can never belong to a sample
  // accepted at that very edge.
  always @(posedge clk) begin : result_check
    filt_res_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: result with no sample outstanding: x=%0d y=%0d z=%0d clipped=%0b",
                   $time, x_filtered, y_filtered, z_filtered, clipped);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          check_field("x_filtered", want.x, x_filtered);
          check_field("y_filtered", want.y, y_filtered);
          check_field("z_filtered", want.z, z_filtered);
          check_field("clipped", int'(want.clip), int'(clipped));
        end
      end
      if (in_valid && !in_stall) filtered_q.push_back(pending_result);
    end
  end

  // Ends a hung run: any transfer on any channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   row;
    cfg_style_t style;
    int         sent;
    int         block_len;
    int         block_count;

    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = REG_GAIN;
    cfg_data       = '0;
    in_valid       = 1'b0;
    x_sample       = '0;
    y_sample       = '0;
    z_sample       = '0;
    start_of_block = 1'b0;
    fail_count     = 0;
    pending_result = '0;

    // Predictor state matches the block after reset: unit gain and b0, all history clear.
    foreach (coef_now[i]) coef_now[i] = '0;
    coef_now[REG_GAIN] = COEF_ONE;
    coef_now[REG_B0]   = COEF_ONE;
    foreach (in_hist[a, k]) begin
      in_hist[a][k]  = '0;
      out_hist[a][k] = '0;
    end
    warm_count = 0;

    // First idling mode: the sender idles a quarter of the time, the receiver most of it.
    send_gap_pct   = 25;
    recv_stall_pct = 64;

    // Directed table. The first two samples after reset come without a start mark and still
    // fall in warm-up, so they give zeros.
    add_checked(100, -200, 300, 1'b0, 0, 0, 0, 1'b0);
    add_checked(SAMPLE_MAX, SAMPLE_MIN, 1, 1'b0, 0, 0, 0, 1'b0);
    // Reset coefficients form a unit filter, so every later output equals its input.
    add_checked(SAMPLE_MIN, SAMPLE_MAX, -1, 1'b0, SAMPLE_MIN, SAMPLE_MAX, -1, 1'b0);
    add_checked(0, 0, 0, 1'b0, 0, 0, 0, 1'b0);
    add_checked(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0,
                SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    add_checked(-1, 16'h5555, 16'hAAAA, 1'b0, -1, 16'h5555, 16'hAAAA, 1'b0);
    // A start mark restarts warm-up for two samples.
    add_checked(12345, -12345, 7, 1'b1, 0, 0, 0, 1'b0);
    add_checked(1, 2, 3, 1'b0, 0, 0, 0, 1'b0);
    add_checked(4, 5, 6, 1'b0, 4, 5, 6, 1'b0);
    // Start marks back to back keep the block in warm-up.
    add_checked(-9, 9, -9, 1'b1, 0, 0, 0, 1'b0);
    add_checked(-7, 7, -7, 1'b1, 0, 0, 0, 1'b0);
    add_checked(8, 8, 8, 1'b0, 0, 0, 0, 1'b0);
    add_checked(-8, 16'h7F00, -32767, 1'b0, -8, 16'h7F00, -32767, 1'b0);
    // Largest gain and b0, just under 8.0 each: the full-scale samples saturate.
    add_write(REG_GAIN, COEF_MAX);
    add_write(REG_B0, COEF_MAX);
    add_checked(SAMPLE_MAX, SAMPLE_MIN, 0, 1'b0, SAMPLE_MAX, SAMPLE_MIN, 0, 1'b1);
    add_checked(0, 0, 0, 1'b0, 0, 0, 0, 1'b0);
    // 512 lands just below the positive limit; -1 shows truncation toward minus infinity.
    add_item(1, -1, 512, 1'b0);
    add_item(511, -512, -513, 1'b1);
    // Every weight at an extreme, with signs chosen to pull in opposite directions.
    add_write(REG_GAIN, COEF_MIN);
    add_write(REG_B0, COEF_MIN);
    add_write(REG_B1, COEF_MAX);
    add_write(REG_B2, COEF_MIN);
    add_write(REG_A1, COEF_MAX);
    add_write(REG_A2, COEF_MIN);
    add_item(SAMPLE_MAX, SAMPLE_MIN, 3, 1'b0);
    add_item(SAMPLE_MIN, -1, 0, 1'b0);
    add_item(-1, SAMPLE_MAX, -3, 1'b0);
    // A write to an unused index must leave every coefficient alone.
    add_write(REG_SPARE_HI, COEF_MAX);
    add_item(2, -2, 1000, 1'b0);
    // Zero gain forces every result to zero whatever the history holds.
    add_write(REG_GAIN, '0);
    add_checked(SAMPLE_MAX, SAMPLE_MIN, 77, 1'b0, 0, 0, 0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained(1'b1);
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.x, row.y, row.z, row.sob, row.typed, row.want);
      end
    end

    // Random part: each phase loads a new coefficient set while idle, then streams blocks.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) begin
        send_gap_pct   = 64;
        recv_stall_pct = 25;
      end
      if (p == 6) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0:       style = CFG_RESET;
        1, 4:    style = CFG_FILTER;
        3:       style = CFG_ALL_MAX;
        5:       style = CFG_ALL_MIN;
        6:       style = CFG_SMALL;
        default: style = CFG_RANDOM;
      endcase

      wait_drained(1'b1);
      for (int r = REG_GAIN; r <= REG_A2; r++) write_reg(3'(r), pick_coef(style, r));
      if ($urandom_range(1))
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, coef_t'($urandom));

      sent        = 0;
      block_count = 0;
      while (sent < ITEMS_PER_PHASE) begin
        block_count++;
        // Now and then the sender holds back until every result is in.
        if (block_count % 7 == 3) wait_drained(1'b0);
        if ($urandom_range(7) == 0) begin
          // Stray sample with a random start mark, breaking up the block structure.
          send_sample(pick_sample(), pick_sample(), pick_sample(), 1'($urandom_range(1)),
                      1'b0, '0);
          sent++;
        end else begin
          // A well-formed block: start mark on the first sample only.
          block_len = $urandom_range(3, 24);
          for (int k = 0; k < block_len; k++)
            send_sample(pick_sample(), pick_sample(), pick_sample(), k == 0, 1'b0, '0);
          sent += block_len;
        end
      end
    end

    wait_drained(1'b1);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
